### rtl/core/lac_pkg.sv
// types and constants shared by the letter anagram checker modules
// no dependencies

package lac_pkg;

  localparam int LETTERS = 26;
  localparam int IDX_W = 5;
  localparam int TOTAL_W = 11;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

  typedef enum logic [1:0] {
    OP_CLR_REF  = 2'd0,
    OP_ADD_REF  = 2'd1,
    OP_ADD_CAND = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_CLR_REF  = 2'd0,
    CMD_ADD_REF  = 2'd1,
    CMD_ADD_CAND = 2'd2
  } cmd_t;

  // classified item as it travels from front to back
  typedef struct packed {
    cmd_t             cmd;
    logic             is_letter;
    logic [IDX_W-1:0] idx;
    logic             last;
  } entry_t;

endpackage

### rtl/core/lac_queue.sv
// short queue between the classifier front and the histogram back
// depends on lac_pkg

module lac_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lac_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output lac_pkg::entry_t head,
  output logic            head_valid
);

  localparam int Depth = lac_pkg::QDEPTH;
  localparam int Aw = lac_pkg::QAW;

  lac_pkg::entry_t      slots [Depth];
  logic [Aw-1:0]        wr_ptr;
  logic [Aw-1:0]        rd_ptr;
  logic [Aw:0]          count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == (Aw+1)'(Depth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Aw+1)'(Depth))
    else $error("queue count above depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

### rtl/core/lac_front.sv
// front end: input handshake, letter decode and case folding
// depends on lac_pkg

module lac_front (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [7:0]              char_code,
  input  logic                    is_last,
  input  logic                    q_full,
  output logic                    push,
  output lac_pkg::entry_t         push_entry
);

  logic is_lower;
  logic is_upper;
  logic keep;

  always_comb begin
    is_lower = (char_code >= lac_pkg::CHAR_LOWER_A) && (char_code <= lac_pkg::CHAR_LOWER_Z);
    is_upper = (char_code >= lac_pkg::CHAR_UPPER_A) && (char_code <= lac_pkg::CHAR_UPPER_Z);
    push_entry.is_letter = is_lower || is_upper;
    push_entry.idx = is_lower ? lac_pkg::IDX_W'(char_code - lac_pkg::CHAR_LOWER_A)
                              : lac_pkg::IDX_W'(char_code - lac_pkg::CHAR_UPPER_A);
    push_entry.last = is_last;
    push_entry.cmd  = lac_pkg::CMD_CLR_REF;
    keep = 1'b0;
    // transactions with no effect on state are dropped here
    case (lac_pkg::op_t'(opcode))
      lac_pkg::OP_CLR_REF: begin
        push_entry.cmd = lac_pkg::CMD_CLR_REF;
        keep = 1'b1;
      end
      lac_pkg::OP_ADD_REF: begin
        push_entry.cmd = lac_pkg::CMD_ADD_REF;
        keep = is_lower || is_upper;
      end
      lac_pkg::OP_ADD_CAND: begin
        push_entry.cmd = lac_pkg::CMD_ADD_CAND;
        keep = is_lower || is_upper || is_last;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && keep;

endmodule

### rtl/core/lac_back.sv
// back end: reference and candidate histograms, compare and result register
// depends on lac_pkg

module lac_back #(
  parameter int MAX_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lac_pkg::entry_t             head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_match,
  output logic [lac_pkg::TOTAL_W-1:0] letter_total
);

  localparam int Letters = lac_pkg::LETTERS;
  localparam int Cw = $clog2(MAX_LEN + 1);
  localparam int TotW = lac_pkg::TOTAL_W;
  localparam logic [Cw-1:0] CntMax = Cw'(MAX_LEN);

  logic [Cw-1:0]      ref_cnt  [Letters];
  logic [Cw-1:0]      cand_cnt [Letters];
  logic [Cw-1:0]      total;
  // eq[k] tracks cand_cnt[k] == ref_cnt[k]
  logic [Letters-1:0] eq;

  logic [Cw-1:0]      ref_sel;
  logic [Cw-1:0]      cand_sel;
  logic [Cw-1:0]      ref_inc;
  logic [Cw-1:0]      cand_inc;
  logic [Cw-1:0]      total_next;
  logic [Letters-1:0] eq_next_mod;
  logic [Letters-1:0] eq_check;
  logic               cand_last;
  logic               match_now;

  function automatic logic [Cw-1:0] sat_inc(input logic [Cw-1:0] v);
    return (v >= CntMax) ? CntMax : v + 1'b1;
  endfunction

  always_comb begin
    ref_sel    = ref_cnt[head.idx];
    cand_sel   = cand_cnt[head.idx];
    ref_inc    = sat_inc(ref_sel);
    cand_inc   = sat_inc(cand_sel);
    total_next = head.is_letter ? sat_inc(total) : total;
    cand_last  = (head.cmd == lac_pkg::CMD_ADD_CAND) && head.last;
    eq_next_mod = eq;
    if (head.is_letter) begin
      eq_next_mod[head.idx] = (cand_inc == ref_sel);
    end
    match_now = &eq_next_mod;
    for (int k = 0; k < Letters; k++) begin
      eq_check[k] = (cand_cnt[k] == ref_cnt[k]);
    end
  end

  // a result-free transaction may pass a held result
  assign pop = head_valid && (!out_valid || out_ready || !cand_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Letters; k++) begin
        ref_cnt[k]  <= '0;
        cand_cnt[k] <= '0;
      end
      total     <= '0;
      eq        <= '1;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !(pop && cand_last)) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (head.cmd)
          lac_pkg::CMD_CLR_REF: begin
            for (int k = 0; k < Letters; k++) begin
              ref_cnt[k] <= '0;
              eq[k]      <= (cand_cnt[k] == '0);
            end
          end
          lac_pkg::CMD_ADD_REF: begin
            if (head.is_letter) begin
              ref_cnt[head.idx] <= ref_inc;
              eq[head.idx]      <= (ref_inc == cand_sel);
            end
          end
          lac_pkg::CMD_ADD_CAND: begin
            if (head.last) begin
              for (int k = 0; k < Letters; k++) begin
                cand_cnt[k] <= '0;
                eq[k]       <= (ref_cnt[k] == '0);
              end
              total        <= '0;
              out_valid    <= 1'b1;
              is_match     <= match_now;
              letter_total <= TotW'(total_next);
            end else if (head.is_letter) begin
              cand_cnt[head.idx] <= cand_inc;
              eq[head.idx]       <= (cand_inc == ref_sel);
              total              <= total_next;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_eq_tracks: assert property (@(posedge clk) disable iff (rst)
    eq == eq_check)
    else $error("equality flags out of step with histograms");

  a_total_sat: assert property (@(posedge clk) disable iff (rst)
    total <= CntMax)
    else $error("letter count above saturation limit");

  a_cand_cleared: assert property (@(posedge clk) disable iff (rst)
    (pop && cand_last) |=> (total == '0) && out_valid)
    else $error("candidate not closed after last character");

endmodule

### rtl/core/letter_anagram_checker.sv
// top level of the letter anagram checker
// depends on lac_pkg, lac_front, lac_queue, lac_back
//
// input channel (in_valid/in_ready) carries opcode, char_code and is_last:
//   opcode 0 clears the reference histogram, 1 adds a reference byte,
//   2 adds a candidate byte; opcode 3 is accepted and ignored.
// only letters count, upper case folded to lower case; other bytes are dropped.
// a candidate byte with is_last high closes the line and produces one result
// on the output channel (out_valid/out_ready): is_match and letter_total.
// one byte is accepted per cycle while the queue is not full; out_valid rises
// when the last byte, having passed through the four-entry queue, is moved from
// the queue head into the result register.
// when out_ready is low the held result stays; bytes that make no result keep
// flowing into the histograms, and the queue fills and drops in_ready only
// when another closing byte is waiting behind the held result.
// reset clears both histograms and the letter count.

module letter_anagram_checker #(
  parameter int MAX_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [7:0]                  char_code,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_match,
  output logic [lac_pkg::TOTAL_W-1:0] letter_total
);

  logic            push;
  lac_pkg::entry_t push_entry;
  logic            q_full;
  logic            pop;
  lac_pkg::entry_t head;
  logic            head_valid;

  lac_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .char_code  (char_code),
    .is_last    (is_last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  lac_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_match     (is_match),
    .letter_total (letter_total)
  );

endmodule
